/* design/fbbc_pkg.sv */
package fbbc_pkg;

    localparam int ADDR_W      = 24;
    localparam int SECT_W      = 16;
    localparam int CHIP_W      = 3;
    localparam int BOFF_W      = 16;
    localparam int CNT_W       = 32;
    localparam int MAX_RESULTS = 34;
    localparam int RES_CNT_W   = 6;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_HOST_TO_BUF  = 3'd0,
        OP_BUF_TO_HOST  = 3'd1,
        OP_PAGE_TO_BUF  = 3'd2,
        OP_PAGE_WRITE   = 3'd3,
        OP_ERASE        = 3'd4,
        OP_PAGE_TO_HOST = 3'd5,
        OP_DONE         = 3'd6
    } t_op;

    typedef struct packed {
        logic accept;
        logic off_clr;
        logic off_adv;
        logic div_go;
        logic div_page;
        logic set_cur;
        logic clr_valid;
        logic emit;
        t_op  op;
        logic last;
    } t_ctrl_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic hit;
        logic buf_valid;
        logic div_done;
        logic off_last_blk;
        logic off_last_sec;
    } t_ctrl_sts;

endpackage

/* design/fbbc_div.sv */
module fbbc_div #(
    parameter int CHIPS = 2,
    parameter int BW    = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [BW-1:0]                i_dividend,
    output logic                         o_done,
    output logic [BW-1:0]                o_quot,
    output logic [fbbc_pkg::CHIP_W-1:0]  o_rem
);
    import fbbc_pkg::*;

    localparam int L  = $clog2(CHIPS);
    localparam int S  = BW + L;
    localparam int MW = S + 1;
    localparam int PW = BW + MW;
    localparam longint unsigned MULT_VAL = ((64'd1 << S) + 64'(CHIPS) - 64'd1) / 64'(CHIPS);
    localparam logic [MW-1:0] MULT = MW'(MULT_VAL);

    logic          r_v1;
    logic          r_v2;
    logic [PW-1:0] r_prod;
    logic [BW-1:0] r_b;
    logic [BW-1:0] w_q;
    logic [BW-1:0] w_qc;
    logic [BW-1:0] w_rem;

    assign w_q   = BW'(r_prod >> S);
    assign w_qc  = w_q * BW'(CHIPS);
    assign w_rem = r_b - w_qc;
    assign o_done = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_go;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_prod <= PW'(i_dividend) * PW'(MULT);
            r_b    <= i_dividend;
        end
        if (r_v1) begin
            o_quot <= w_q;
            o_rem  <= CHIP_W'(w_rem);
        end
    end

endmodule

/* design/fbbc_ctrl.sv */
module fbbc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  fbbc_pkg::t_ctrl_sts   i_sts,
    output fbbc_pkg::t_ctrl_cmd   o_cmd
);
    import fbbc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_PREP  = 11'b000_0000_0010,
        S_DIVW  = 11'b000_0000_0100,
        S_WB    = 11'b000_0000_1000,
        S_LD    = 11'b000_0001_0000,
        S_ER    = 11'b000_0010_0000,
        S_CP    = 11'b000_0100_0000,
        S_RDIV  = 11'b000_1000_0000,
        S_RWAIT = 11'b001_0000_0000,
        S_RD    = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [RES_CNT_W-1:0] r_cnt;
    logic [RES_CNT_W-1:0] n_cnt;
    logic                 w_at_limit;

    assign w_at_limit = (r_cnt == RES_CNT_W'(MAX_RESULTS - 1));
    assign o_busy     = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd     = '0;
        o_cmd.op  = OP_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_cnt        = '0;
                    n_state      = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.off_clr = 1'b1;
                case (i_sts.cmd)
                    CMD_WRITE: begin
                        if (i_sts.hit) begin
                            n_state = S_CP;
                        end else begin
                            o_cmd.div_go = 1'b1;
                            n_state      = S_DIVW;
                        end
                    end
                    CMD_READ: begin
                        n_state = i_sts.hit ? S_CP : S_RDIV;
                    end
                    CMD_FLUSH: begin
                        n_state = i_sts.buf_valid ? S_WB : S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    if (i_sts.buf_valid) begin
                        n_state = S_WB;
                    end else begin
                        o_cmd.set_cur = 1'b1;
                        n_state       = S_LD;
                    end
                end
            end
            S_WB: begin
                o_cmd.emit    = 1'b1;
                o_cmd.op      = OP_PAGE_WRITE;
                o_cmd.off_adv = 1'b1;
                if (w_at_limit || i_sts.off_last_blk) begin
                    if (i_sts.cmd == CMD_FLUSH) begin
                        o_cmd.clr_valid = 1'b1;
                        o_cmd.last      = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.set_cur = 1'b1;
                        if (w_at_limit) begin
                            o_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            o_cmd.off_clr = 1'b1;
                            n_state       = S_LD;
                        end
                    end
                end
            end
            S_LD: begin
                o_cmd.emit    = 1'b1;
                o_cmd.op      = OP_PAGE_TO_BUF;
                o_cmd.off_adv = 1'b1;
                if (w_at_limit) begin
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_sts.off_last_blk) begin
                    n_state = S_ER;
                end
            end
            S_ER: begin
                o_cmd.emit = 1'b1;
                o_cmd.op   = OP_ERASE;
                if (w_at_limit) begin
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_CP;
                end
            end
            S_CP: begin
                o_cmd.emit = 1'b1;
                o_cmd.op   = (i_sts.cmd == CMD_WRITE) ? OP_HOST_TO_BUF : OP_BUF_TO_HOST;
                o_cmd.last = 1'b1;
                n_state    = S_IDLE;
            end
            S_RDIV: begin
                o_cmd.div_go   = 1'b1;
                o_cmd.div_page = 1'b1;
                n_state        = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.emit    = 1'b1;
                o_cmd.op      = OP_PAGE_TO_HOST;
                o_cmd.off_adv = 1'b1;
                if (w_at_limit || i_sts.off_last_sec) begin
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_RDIV;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                o_cmd.op   = OP_DONE;
                o_cmd.last = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.emit) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_emit_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_cnt < RES_CNT_W'(MAX_RESULTS)))
        else $error("result count past limit");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> !o_busy)
        else $error("still busy after final result");

    a_div_wait_after_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_go |=> !i_sts.div_done)
        else $error("division done too early");

endmodule

/* design/fbbc_dpath.sv */
module fbbc_dpath #(
    parameter int SECTOR_BYTES = 512,
    parameter int BLOCK_BYTES  = 4096,
    parameter int PAGE_BYTES   = 256,
    parameter int CHIPS        = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fbbc_pkg::t_ctrl_cmd          i_cmd,
    output fbbc_pkg::t_ctrl_sts          o_sts,
    input  logic [1:0]                   i_command,
    input  logic [fbbc_pkg::SECT_W-1:0]  i_sector_number,
    input  logic                         i_clear_activity,
    input  logic                         i_cfg_valid,
    input  logic [fbbc_pkg::ADDR_W-1:0]  i_cfg_data,
    output logic                         o_valid,
    output logic [2:0]                   o_operation,
    output logic [fbbc_pkg::CHIP_W-1:0]  o_chip_select,
    output logic [fbbc_pkg::ADDR_W-1:0]  o_flash_address,
    output logic [fbbc_pkg::BOFF_W-1:0]  o_buffer_offset,
    output logic                         o_last,
    output logic                         o_write_activity,
    output logic                         o_read_activity,
    output logic [fbbc_pkg::CNT_W-1:0]   o_sectors_written,
    output logic [fbbc_pkg::CNT_W-1:0]   o_sectors_read
);
    import fbbc_pkg::*;

    localparam int SEC_LOG = $clog2(SECTOR_BYTES);
    localparam int BLK_LOG = $clog2(BLOCK_BYTES);
    localparam int START_W = SECT_W + SEC_LOG;
    localparam int BW      = START_W - BLK_LOG;
    localparam int MAX_SB  = (SECTOR_BYTES > BLOCK_BYTES) ? SECTOR_BYTES : BLOCK_BYTES;
    localparam int MAX_B   = (PAGE_BYTES > MAX_SB) ? PAGE_BYTES : MAX_SB;
    localparam int OC_W    = $clog2(MAX_B) + 2;

    t_cmd               r_cmd;
    logic [SECT_W-1:0]  r_sector;
    logic               r_clr;
    logic [ADDR_W-1:0]  r_base;
    logic [BW-1:0]      r_cur_blk;
    logic [CHIP_W-1:0]  r_cur_chip;
    logic [ADDR_W-1:0]  r_cur_baddr;
    logic               r_valid;
    logic [CNT_W-1:0]   r_wcnt;
    logic [CNT_W-1:0]   r_rcnt;
    logic               r_wflag;
    logic               r_rflag;
    logic [OC_W-1:0]    r_off;

    logic [START_W-1:0] w_start;
    logic [BW-1:0]      w_blk;
    logic [BLK_LOG-1:0] w_pos;
    logic [START_W-1:0] w_addr_rd;
    logic [BW-1:0]      w_pblk;
    logic [BW-1:0]      w_div_in;
    logic               w_div_done;
    logic [BW-1:0]      w_div_q;
    logic [CHIP_W-1:0]  w_div_r;
    logic [31:0]        w_qshift;
    logic [ADDR_W-1:0]  w_div_baddr;
    logic [OC_W-1:0]    w_off_next;
    logic [CHIP_W-1:0]  w_chip;
    logic [ADDR_W-1:0]  w_addr;
    logic [BOFF_W-1:0]  w_boff;

    assign w_start     = {r_sector, {SEC_LOG{1'b0}}};
    assign w_blk       = w_start[START_W-1:BLK_LOG];
    assign w_pos       = w_start[BLK_LOG-1:0];
    assign w_addr_rd   = w_start + START_W'(r_off);
    assign w_pblk      = w_addr_rd[START_W-1:BLK_LOG];
    assign w_div_in    = i_cmd.div_page ? w_pblk : w_blk;
    assign w_qshift    = 32'(w_div_q) << BLK_LOG;
    assign w_div_baddr = w_qshift[ADDR_W-1:0];
    assign w_off_next  = r_off + OC_W'(PAGE_BYTES);

    fbbc_div #(
        .CHIPS (CHIPS),
        .BW    (BW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (w_div_in),
        .o_done     (w_div_done),
        .o_quot     (w_div_q),
        .o_rem      (w_div_r)
    );

    always_comb begin
        o_sts.cmd          = r_cmd;
        o_sts.hit          = r_valid && (r_cur_blk == w_blk);
        o_sts.buf_valid    = r_valid;
        o_sts.div_done     = w_div_done;
        o_sts.off_last_blk = (w_off_next >= OC_W'(BLOCK_BYTES));
        o_sts.off_last_sec = (w_off_next >= OC_W'(SECTOR_BYTES));
    end

    always_comb begin
        w_chip = '0;
        w_addr = '0;
        w_boff = '0;
        case (i_cmd.op)
            OP_PAGE_WRITE, OP_PAGE_TO_BUF: begin
                w_chip = r_cur_chip;
                w_addr = r_base + r_cur_baddr + ADDR_W'(r_off);
                w_boff = BOFF_W'(r_off);
            end
            OP_ERASE: begin
                w_chip = r_cur_chip;
                w_addr = r_base + r_cur_baddr;
            end
            OP_PAGE_TO_HOST: begin
                w_chip = w_div_r;
                w_addr = r_base + w_div_baddr + ADDR_W'(w_addr_rd[BLK_LOG-1:0]);
                w_boff = BOFF_W'(r_off);
            end
            OP_HOST_TO_BUF, OP_BUF_TO_HOST: begin
                w_boff = BOFF_W'(w_pos);
            end
            default: begin
                w_chip = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_valid <= 1'b0;
            r_wcnt  <= '0;
            r_rcnt  <= '0;
            r_wflag <= 1'b0;
            r_rflag <= 1'b0;
            r_off   <= '0;
            o_valid <= 1'b0;
            o_last  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                case (t_cmd'(i_command))
                    CMD_WRITE: begin
                        r_wcnt  <= r_wcnt + 1'b1;
                        r_wflag <= 1'b1;
                    end
                    CMD_READ: begin
                        r_rcnt  <= r_rcnt + 1'b1;
                        r_rflag <= 1'b1;
                    end
                    CMD_CLEAR: begin
                        r_wcnt <= '0;
                        r_rcnt <= '0;
                    end
                    default: begin
                        r_wflag <= r_wflag;
                    end
                endcase
            end
            if (i_cmd.set_cur) begin
                r_valid <= 1'b1;
            end else if (i_cmd.clr_valid) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.off_clr) begin
                r_off <= '0;
            end else if (i_cmd.off_adv) begin
                r_off <= w_off_next;
            end
            if (i_cmd.emit && i_cmd.last && r_clr) begin
                r_wflag <= 1'b0;
                r_rflag <= 1'b0;
            end
            o_valid <= i_cmd.emit;
            o_last  <= i_cmd.emit && i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= t_cmd'(i_command);
            r_sector <= i_sector_number;
            r_clr    <= i_clear_activity;
        end
        if (i_cmd.set_cur) begin
            r_cur_blk   <= w_blk;
            r_cur_chip  <= w_div_r;
            r_cur_baddr <= w_div_baddr;
        end
        if (i_cmd.emit) begin
            o_operation       <= i_cmd.op;
            o_chip_select     <= w_chip;
            o_flash_address   <= w_addr;
            o_buffer_offset   <= w_boff;
            o_write_activity  <= r_wflag;
            o_read_activity   <= r_rflag;
            o_sectors_written <= r_wcnt;
            o_sectors_read    <= r_rcnt;
        end
    end

endmodule

/* design/flash_block_buffer_controller_top.sv */
// A buffer hit shows its one result; a write miss waits for the chip/block division and
// then shows one result per cycle (up to 34). Requests are taken one at a time, as the
// flash command sequencer stays busy until the final result; a direct read runs the
// chip/block division anew for each page before that page's result is shown.
// Results are strobed for one cycle and the receiver cannot stall; a new start is taken
// while the final result is on the ports. Synchronous active-low reset empties the buffer.
module flash_block_buffer_controller_top #(
    parameter int SECTOR_BYTES = 512,
    parameter int BLOCK_BYTES  = 4096,
    parameter int PAGE_BYTES   = 256,
    parameter int CHIPS        = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [1:0]   i_command,
    input  logic [15:0]  i_sector_number,
    input  logic         i_clear_activity,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [23:0]  i_cfg_data,
    output logic         o_valid,
    output logic [2:0]   o_operation,
    output logic [2:0]   o_chip_select,
    output logic [23:0]  o_flash_address,
    output logic [15:0]  o_buffer_offset,
    output logic         o_last,
    output logic         o_write_activity,
    output logic         o_read_activity,
    output logic [31:0]  o_sectors_written,
    output logic [31:0]  o_sectors_read
);
    import fbbc_pkg::*;

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;
    logic      w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    fbbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    fbbc_dpath #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .PAGE_BYTES   (PAGE_BYTES),
        .CHIPS        (CHIPS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_command         (i_command),
        .i_sector_number   (i_sector_number),
        .i_clear_activity  (i_clear_activity),
        .i_cfg_valid       (w_cfg_wr),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_operation       (o_operation),
        .o_chip_select     (o_chip_select),
        .o_flash_address   (o_flash_address),
        .o_buffer_offset   (o_buffer_offset),
        .o_last            (o_last),
        .o_write_activity  (o_write_activity),
        .o_read_activity   (o_read_activity),
        .o_sectors_written (o_sectors_written),
        .o_sectors_read    (o_sectors_read)
    );

    a_mid_item_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("idle with results outstanding");

    a_no_result_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result right after transfer in");

    a_last_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last without strobe");

endmodule
